>>> rtl/core/psdd_pkg.sv
// ----------------------------------------------------------------------------
// psdd_pkg
// Shared types and constants of the pulse signature device detector.
// ----------------------------------------------------------------------------
package psdd_pkg;

    localparam int TIME_BITS = 16;
    localparam int IDLE_BITS = 14;
    localparam int RUN_BITS  = 5;
    localparam int CFG_BITS  = 3;
    localparam int DATA_BITS = 16;

    localparam logic [TIME_BITS-1:0] TIME_MASK = {TIME_BITS{1'b1}};
    localparam logic [IDLE_BITS-1:0] IDLE_MAX  = {IDLE_BITS{1'b1}};
    localparam logic [RUN_BITS-1:0]  RUN_MAX   = {RUN_BITS{1'b1}};
    localparam logic [RUN_BITS-1:0]  LOSS_START = RUN_BITS'(10);
    localparam logic [RUN_BITS-1:0]  LOSS_DROP  = RUN_BITS'(5);

    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_VALID  = 2'd1;
    localparam logic [1:0] PH_ATTACH = 2'd2;

    localparam logic [1:0] DEV_NONE   = 2'd0;
    localparam logic [1:0] DEV_REMOTE = 2'd1;
    localparam logic [1:0] DEV_PROBE  = 2'd2;

    localparam logic [CFG_BITS-1:0] REG_MIN_HIGH       = 3'd0;
    localparam logic [CFG_BITS-1:0] REG_MIN_PERIOD     = 3'd1;
    localparam logic [CFG_BITS-1:0] REG_REMOTE_LIMIT   = 3'd2;
    localparam logic [CFG_BITS-1:0] REG_PROBE_LOW      = 3'd3;
    localparam logic [CFG_BITS-1:0] REG_PROBE_HIGH     = 3'd4;
    localparam logic [CFG_BITS-1:0] REG_VALIDATE_COUNT = 3'd5;
    localparam logic [CFG_BITS-1:0] REG_VALID_TIMEOUT  = 3'd6;
    localparam logic [CFG_BITS-1:0] REG_ATTACH_TIMEOUT = 3'd7;

    typedef struct packed {
        logic [TIME_BITS-1:0] min_high_time;
        logic [TIME_BITS-1:0] min_period;
        logic [TIME_BITS-1:0] remote_period_limit;
        logic [TIME_BITS-1:0] probe_period_low;
        logic [TIME_BITS-1:0] probe_period_high;
        logic [RUN_BITS-1:0]  validate_count;
        logic [IDLE_BITS-1:0] validating_timeout;
        logic [IDLE_BITS-1:0] attached_timeout;
    } cfg_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] high_time;
        logic [TIME_BITS-1:0] low_time;
        logic [TIME_BITS-1:0] period;
        logic                 noise;
        logic                 search_ok;
        logic [1:0]           period_kind;
    } meas_t;

    typedef struct packed {
        logic [1:0]           attach_phase;
        logic [1:0]           device_kind;
        logic                 measure_valid;
        logic [TIME_BITS-1:0] measured_high;
        logic [TIME_BITS-1:0] measured_low;
        logic [TIME_BITS-1:0] measured_period;
    } result_t;

endpackage

>>> rtl/core/psdd_measure.sv
// ----------------------------------------------------------------------------
// psdd_measure
// Derives low, high and period from the edge timestamps a, b and c and classifies them.
// ----------------------------------------------------------------------------
module psdd_measure (
    input  logic [psdd_pkg::TIME_BITS-1:0] edge_time_a,
    input  logic [psdd_pkg::TIME_BITS-1:0] edge_time_b,
    input  logic [psdd_pkg::TIME_BITS-1:0] edge_time_c,
    input  psdd_pkg::cfg_t                 cfg,
    output psdd_pkg::meas_t                meas
);

    logic [psdd_pkg::TIME_BITS-1:0] low_raw;
    logic [psdd_pkg::TIME_BITS-1:0] high_raw;
    logic [psdd_pkg::TIME_BITS-1:0] low_time;
    logic [psdd_pkg::TIME_BITS-1:0] high_time;
    logic [psdd_pkg::TIME_BITS-1:0] period;

    // The wrapped difference is folded modulo the all-ones value.
    assign low_raw   = edge_time_b - edge_time_a;
    assign high_raw  = edge_time_c - edge_time_b;
    assign low_time  = (low_raw == psdd_pkg::TIME_MASK) ? '0 : low_raw;
    assign high_time = (high_raw == psdd_pkg::TIME_MASK) ? '0 : high_raw;
    assign period    = high_time + low_time;

    always_comb
    begin
        meas.high_time = high_time;
        meas.low_time  = low_time;
        meas.period    = period;
        meas.noise     = (high_time < cfg.min_high_time) || (period < cfg.min_period);
        meas.search_ok = (high_time > cfg.min_high_time) && (period > cfg.min_period)
                         && (period < cfg.probe_period_high);
        if (period < cfg.remote_period_limit)
        begin
            meas.period_kind = psdd_pkg::DEV_REMOTE;
        end
        else if ((period > cfg.probe_period_low) && (period < cfg.probe_period_high))
        begin
            meas.period_kind = psdd_pkg::DEV_PROBE;
        end
        else
        begin
            meas.period_kind = psdd_pkg::DEV_NONE;
        end
    end

endmodule

>>> rtl/core/psdd_track.sv
// ----------------------------------------------------------------------------
// psdd_track
// Attach state machine with run, loss and idle counters and measurement holds.
// ----------------------------------------------------------------------------
module psdd_track (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              command,
    input  psdd_pkg::meas_t   meas,
    input  psdd_pkg::cfg_t    cfg,
    output psdd_pkg::result_t result
);

    logic [1:0]                     phase_reg;
    logic [1:0]                     phase_next;
    logic [1:0]                     device_reg;
    logic [1:0]                     device_next;
    logic [1:0]                     prev_device_reg;
    logic [1:0]                     prev_device_next;
    logic [psdd_pkg::RUN_BITS-1:0]  run_reg;
    logic [psdd_pkg::RUN_BITS-1:0]  run_next;
    logic [psdd_pkg::IDLE_BITS-1:0] idle_reg;
    logic [psdd_pkg::IDLE_BITS-1:0] idle_next;
    logic [psdd_pkg::TIME_BITS-1:0] high_hold_reg;
    logic [psdd_pkg::TIME_BITS-1:0] low_hold_reg;
    logic [psdd_pkg::TIME_BITS-1:0] period_hold_reg;
    logic                           load_hold;
    logic [psdd_pkg::RUN_BITS-1:0]  run_kept;
    logic [psdd_pkg::IDLE_BITS-1:0] idle_limit;
    logic [psdd_pkg::IDLE_BITS-1:0] idle_inc;
    logic                           match_ok;

    assign idle_limit = (phase_reg == psdd_pkg::PH_VALID) ? cfg.validating_timeout
                                                           : cfg.attached_timeout;
    assign idle_inc   = (idle_reg < psdd_pkg::IDLE_MAX) ? idle_reg + 1'b1 : idle_reg;
    assign match_ok   = !meas.noise && (meas.period_kind != psdd_pkg::DEV_NONE)
                        && (meas.period_kind == device_reg);

    always_comb
    begin
        phase_next       = phase_reg;
        device_next      = device_reg;
        prev_device_next = prev_device_reg;
        run_next         = run_reg;
        idle_next        = idle_reg;
        load_hold        = 1'b0;
        run_kept         = run_reg;
        case (phase_reg)
            psdd_pkg::PH_VALID:
            begin
                if (command)
                begin
                    idle_next = '0;
                    if (meas.noise)
                    begin
                        prev_device_next = psdd_pkg::DEV_NONE;
                        device_next      = psdd_pkg::DEV_NONE;
                    end
                    else
                    begin
                        prev_device_next = device_reg;
                        device_next      = meas.period_kind;
                    end
                    run_kept = (device_next != prev_device_next) ? '0 : run_reg;
                    if (device_next != psdd_pkg::DEV_NONE)
                    begin
                        if (run_kept >= cfg.validate_count)
                        begin
                            phase_next = psdd_pkg::PH_ATTACH;
                            run_next   = psdd_pkg::LOSS_START;
                        end
                        else if (run_kept < psdd_pkg::RUN_MAX)
                        begin
                            run_next = run_kept + 1'b1;
                        end
                        else
                        begin
                            run_next = run_kept;
                        end
                    end
                    else
                    begin
                        run_next   = '0;
                        phase_next = psdd_pkg::PH_SEARCH;
                    end
                end
                else
                begin
                    if (idle_reg >= idle_limit)
                    begin
                        phase_next = psdd_pkg::PH_SEARCH;
                    end
                    idle_next = idle_inc;
                end
            end
            psdd_pkg::PH_ATTACH:
            begin
                if (command)
                begin
                    idle_next = '0;
                    if (match_ok)
                    begin
                        load_hold = 1'b1;
                        run_kept  = psdd_pkg::LOSS_START;
                    end
                    else if (run_reg != '0)
                    begin
                        run_kept = run_reg - 1'b1;
                    end
                    run_next = run_kept;
                    if (run_kept <= psdd_pkg::LOSS_DROP)
                    begin
                        phase_next = psdd_pkg::PH_SEARCH;
                    end
                end
                else
                begin
                    if (idle_reg >= idle_limit)
                    begin
                        phase_next = psdd_pkg::PH_SEARCH;
                    end
                    idle_next = idle_inc;
                end
            end
            default:
            begin
                device_next = psdd_pkg::DEV_NONE;
                run_next    = '0;
                idle_next   = '0;
                phase_next  = (command && meas.search_ok) ? psdd_pkg::PH_VALID
                                                          : psdd_pkg::PH_SEARCH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= psdd_pkg::PH_SEARCH;
            device_reg      <= psdd_pkg::DEV_NONE;
            prev_device_reg <= psdd_pkg::DEV_NONE;
            run_reg         <= '0;
            idle_reg        <= '0;
            high_hold_reg   <= '0;
            low_hold_reg    <= '0;
            period_hold_reg <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            device_reg      <= device_next;
            prev_device_reg <= prev_device_next;
            run_reg         <= run_next;
            idle_reg        <= idle_next;
            if (load_hold)
            begin
                high_hold_reg   <= meas.high_time;
                low_hold_reg    <= meas.low_time;
                period_hold_reg <= meas.period;
            end
        end
    end

    always_comb
    begin
        result.attach_phase    = phase_next;
        result.device_kind     = device_next;
        result.measure_valid   = load_hold;
        result.measured_high   = load_hold ? meas.high_time : high_hold_reg;
        result.measured_low    = load_hold ? meas.low_time : low_hold_reg;
        result.measured_period = load_hold ? meas.period : period_hold_reg;
    end

endmodule

>>> rtl/core/pulse_signature_device_detector.sv
// ----------------------------------------------------------------------------
// pulse_signature_device_detector
// Classifies a socket accessory from pulse edge timestamps and idle ticks.
// ----------------------------------------------------------------------------
// Each item passes through an input register and a result register.
// Throughput: one item per cycle while m_tready does not stall the output;
// the attach state updates once per item.
// Reset clears the state machine, counters, holds and both valid flags, and
// loads the configuration registers with their default values.
module pulse_signature_device_detector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // edge_time_a, edge_time_b, edge_time_c
    input  logic        s_tuser,  // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // attach_phase, measured_high, measured_low,
                                  // measured_period, zero fill
    output logic [2:0]  m_tuser,  // device_kind, measure_valid
    input  logic        cfg_wr_en,
    input  logic [psdd_pkg::CFG_BITS-1:0]  cfg_wr_index,
    input  logic [psdd_pkg::DATA_BITS-1:0] cfg_wr_data
);

    psdd_pkg::cfg_t    cfg_reg;
    psdd_pkg::meas_t   meas;
    psdd_pkg::result_t result;
    psdd_pkg::result_t out_reg;
    logic              in_valid_reg;
    logic              in_cmd_reg;
    logic [47:0]       in_data_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              step;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_high_time       <= 16'd100;
            cfg_reg.min_period          <= 16'd250;
            cfg_reg.remote_period_limit <= 16'd1000;
            cfg_reg.probe_period_low    <= 16'd3000;
            cfg_reg.probe_period_high   <= 16'd20000;
            cfg_reg.validate_count      <= 5'd20;
            cfg_reg.validating_timeout  <= 14'd10000;
            cfg_reg.attached_timeout    <= 14'd100;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_wr_index)
                psdd_pkg::REG_MIN_HIGH:       cfg_reg.min_high_time <= cfg_wr_data;
                psdd_pkg::REG_MIN_PERIOD:     cfg_reg.min_period <= cfg_wr_data;
                psdd_pkg::REG_REMOTE_LIMIT:   cfg_reg.remote_period_limit <= cfg_wr_data;
                psdd_pkg::REG_PROBE_LOW:      cfg_reg.probe_period_low <= cfg_wr_data;
                psdd_pkg::REG_PROBE_HIGH:     cfg_reg.probe_period_high <= cfg_wr_data;
                psdd_pkg::REG_VALIDATE_COUNT:
                    cfg_reg.validate_count <= cfg_wr_data[psdd_pkg::RUN_BITS-1:0];
                psdd_pkg::REG_VALID_TIMEOUT:
                    cfg_reg.validating_timeout <= cfg_wr_data[psdd_pkg::IDLE_BITS-1:0];
                psdd_pkg::REG_ATTACH_TIMEOUT:
                    cfg_reg.attached_timeout <= cfg_wr_data[psdd_pkg::IDLE_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg  <= s_tuser;
            in_data_reg <= s_tdata;
        end
        if (step)
        begin
            out_reg <= result;
        end
    end

    psdd_measure u_measure (
        .edge_time_a (in_data_reg[15:0]),
        .edge_time_b (in_data_reg[31:16]),
        .edge_time_c (in_data_reg[47:32]),
        .cfg         (cfg_reg),
        .meas        (meas)
    );

    psdd_track u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .command (in_cmd_reg),
        .meas    (meas),
        .cfg     (cfg_reg),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.measured_period, out_reg.measured_low,
                       out_reg.measured_high, out_reg.attach_phase};
    assign m_tuser  = {out_reg.measure_valid, out_reg.device_kind};

endmodule

>>> tb/tb_pulse_signature_device_detector.sv
// ----------------------------------------------------------------------------
// tb_pulse_signature_device_detector
// Self-checking bench for the pulse signature device detector. Edge timestamp
// sets and idle ticks are streamed in under random gaps and stalls, each
// transfer is run through a local model of the attach state machine, and
// every result transfer is compared field by field with the oldest prediction
// across several register settings.
// ----------------------------------------------------------------------------
module tb_pulse_signature_device_detector;

    timeunit 1ns;
    timeprecision 1ps;

    import psdd_pkg::*;

    typedef struct packed {
        logic                 cmd;
        logic [TIME_BITS-1:0] a;
        logic [TIME_BITS-1:0] b;
        logic [TIME_BITS-1:0] c;
    } pulse_item_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [55:0]          m_tdata;
    logic [2:0]           m_tuser;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_BITS-1:0]  cfg_wr_index = '0;
    logic [DATA_BITS-1:0] cfg_wr_data = '0;

    pulse_item_t pending_pulses[$];
    result_t     expected_reports[$];
    pulse_item_t offered;
    int          items_queued = 0;
    int          items_taken = 0;
    int          mismatch_count = 0;
    int          send_gap = 0;
    int          stall_gap = 0;
    int          hold_left = 0;
    int          pressure_reqs = 0;
    int          pressure_grants = 0;
    logic        steady_flow = 1'b0;
    result_t     got;
    result_t     want;

    // Model state of the detector.
    cfg_t                 det_cfg;
    logic [1:0]           phase_now;
    logic [1:0]           device_now;
    logic [1:0]           device_before;
    logic [RUN_BITS-1:0]  run_count;
    logic [IDLE_BITS-1:0] idle_count;
    logic [TIME_BITS-1:0] held_high;
    logic [TIME_BITS-1:0] held_low;
    logic [TIME_BITS-1:0] held_period;

    pulse_signature_device_detector dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #10 clk = ~clk;

    function automatic logic [TIME_BITS-1:0] wrapped_span(logic [TIME_BITS-1:0] later,
                                                          logic [TIME_BITS-1:0] earlier);
        logic [TIME_BITS-1:0] d;
        d = later - earlier;
        return (d == TIME_MASK) ? '0 : d;
    endfunction

    function automatic logic [1:0] kind_of_period(logic [TIME_BITS-1:0] per);
        if (per < det_cfg.remote_period_limit)
            return DEV_REMOTE;
        if (per > det_cfg.probe_period_low && per < det_cfg.probe_period_high)
            return DEV_PROBE;
        return DEV_NONE;
    endfunction

    function automatic void count_idle(logic [IDLE_BITS-1:0] limit);
        if (idle_count >= limit)
            phase_now = PH_SEARCH;
        if (idle_count != IDLE_MAX)
            idle_count = idle_count + 1'b1;
    endfunction

    function automatic result_t predict_detector(pulse_item_t it);
        logic [TIME_BITS-1:0] lo;
        logic [TIME_BITS-1:0] hi;
        logic [TIME_BITS-1:0] per;
        logic [1:0]           k;
        logic                 ok;
        result_t              r;
        lo = wrapped_span(it.b, it.a);
        hi = wrapped_span(it.c, it.b);
        per = hi + lo;
        ok = 1'b0;
        if (phase_now == PH_VALID)
        begin
            if (it.cmd)
            begin
                idle_count = '0;
                if (hi < det_cfg.min_high_time || per < det_cfg.min_period)
                begin
                    device_before = DEV_NONE;
                    device_now = DEV_NONE;
                end
                else
                begin
                    device_before = device_now;
                    device_now = kind_of_period(per);
                end
                if (device_now != device_before)
                    run_count = '0;
                if (device_now != DEV_NONE)
                begin
                    if (run_count >= det_cfg.validate_count)
                    begin
                        phase_now = PH_ATTACH;
                        run_count = LOSS_START;
                    end
                    else if (run_count < RUN_MAX)
                        run_count = run_count + 1'b1;
                end
                else
                begin
                    run_count = '0;
                    phase_now = PH_SEARCH;
                end
            end
            else
                count_idle(det_cfg.validating_timeout);
        end
        else if (phase_now == PH_ATTACH)
        begin
            if (it.cmd)
            begin
                idle_count = '0;
                if (hi >= det_cfg.min_high_time && per >= det_cfg.min_period)
                begin
                    k = kind_of_period(per);
                    ok = (k != DEV_NONE) && (k == device_now);
                end
                if (ok)
                begin
                    held_high = hi;
                    held_low = lo;
                    held_period = per;
                    run_count = LOSS_START;
                end
                else if (run_count != 0)
                    run_count = run_count - 1'b1;
                if (run_count <= LOSS_DROP)
                    phase_now = PH_SEARCH;
            end
            else
                count_idle(det_cfg.attached_timeout);
        end
        else
        begin
            phase_now = PH_SEARCH;
            device_now = DEV_NONE;
            run_count = '0;
            idle_count = '0;
            if (it.cmd && hi > det_cfg.min_high_time && per > det_cfg.min_period
                && per < det_cfg.probe_period_high)
                phase_now = PH_VALID;
        end
        r.attach_phase = phase_now;
        r.device_kind = device_now;
        r.measure_valid = ok;
        r.measured_high = held_high;
        r.measured_low = held_low;
        r.measured_period = held_period;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Input side: one transfer per handshake, random gaps between items.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_reports.push_back(predict_detector(offered));
                items_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0 && hold_left == 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_pulses.size() != 0)
                begin
                    offered = pending_pulses.pop_front();
                    s_tdata <= {offered.c, offered.b, offered.a};
                    s_tuser <= offered.cmd;
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Output side: check each result transfer, then decide on stalling.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.attach_phase = m_tdata[1:0];
                got.measured_high = m_tdata[17:2];
                got.measured_low = m_tdata[33:18];
                got.measured_period = m_tdata[49:34];
                got.device_kind = m_tuser[1:0];
                got.measure_valid = m_tuser[2];
                if (expected_reports.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result transfer: phase %0d kind %0d valid %0d",
                                 got.attach_phase, got.device_kind, got.measure_valid);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.attach_phase !== want.attach_phase
                        || got.device_kind !== want.device_kind
                        || got.measure_valid !== want.measure_valid
                        || got.measured_high !== want.measured_high
                        || got.measured_low !== want.measured_low
                        || got.measured_period !== want.measured_period)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"Mismatch: expected phase %0d kind %0d valid %0d ",
                                      "high %0d low %0d period %0d, got phase %0d kind %0d ",
                                      "valid %0d high %0d low %0d period %0d"},
                                     want.attach_phase, want.device_kind,
                                     want.measure_valid, want.measured_high,
                                     want.measured_low, want.measured_period,
                                     got.attach_phase, got.device_kind, got.measure_valid,
                                     got.measured_high, got.measured_low,
                                     got.measured_period);
                    end
                end
            end
            if (hold_left != 0)
                m_tready <= 1'b0;
            else if (stall_gap > 0)
            begin
                stall_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_gap = pick_gap();
            end
        end
    end

    // Long receiver hold-off, so that the block fills and stalls its input.
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (pressure_grants != pressure_reqs)
        begin
            hold_left <= 300;
            pressure_grants <= pressure_grants + 1;
        end
    end

    function automatic int pick_between(int lo, int hi);
        if (lo > hi)
            return $urandom_range(0, 65535);
        return $urandom_range(hi, lo);
    endfunction

    function automatic int clamp16(int v);
        if (v < 0)
            return 0;
        if (v > 65535)
            return 65535;
        return v;
    endfunction

    function automatic pulse_item_t raw_item(logic cmd, int a, int b, int c);
        pulse_item_t it;
        it.cmd = cmd;
        it.a = TIME_BITS'(a);
        it.b = TIME_BITS'(b);
        it.c = TIME_BITS'(c);
        return it;
    endfunction

    function automatic pulse_item_t make_pulse(int hi, int lo);
        int a;
        a = $urandom_range(0, 65535);
        return raw_item(1'b1, a, a + lo, a + lo + hi);
    endfunction

    function automatic pulse_item_t idle_item();
        return raw_item(1'b0, $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535));
    endfunction

    function automatic pulse_item_t class_pulse(logic [1:0] kind);
        int per;
        int hi;
        int floor_per;
        if (kind == DEV_REMOTE)
            per = pick_between(int'(det_cfg.min_period) + 1,
                               int'(det_cfg.remote_period_limit) - 1);
        else
        begin
            floor_per = int'(det_cfg.probe_period_low);
            if (int'(det_cfg.min_period) > floor_per)
                floor_per = int'(det_cfg.min_period);
            per = pick_between(floor_per + 1, int'(det_cfg.probe_period_high) - 1);
        end
        hi = pick_between(int'(det_cfg.min_high_time) + 1, per);
        return make_pulse(hi, (per >= hi) ? per - hi : $urandom_range(0, 65534));
    endfunction

    function automatic pulse_item_t boundary_pulse();
        int t;
        int per;
        int hi;
        case ($urandom_range(0, 4))
            0: t = int'(det_cfg.min_high_time);
            1: t = int'(det_cfg.min_period);
            2: t = int'(det_cfg.remote_period_limit);
            3: t = int'(det_cfg.probe_period_low);
            default: t = int'(det_cfg.probe_period_high);
        endcase
        per = clamp16(t + $urandom_range(0, 2) - 1);
        if ($urandom_range(0, 1) == 0)
            hi = clamp16(int'(det_cfg.min_high_time) + $urandom_range(0, 2) - 1);
        else
            hi = pick_between(int'(det_cfg.min_high_time) + 1, per);
        return make_pulse(hi, (per >= hi) ? per - hi : $urandom_range(0, 65534));
    endfunction

    task automatic add_item(pulse_item_t it);
        pending_pulses.push_back(it);
        items_queued++;
    endtask

    task automatic queue_session();
        int         r;
        int         n;
        int         cap;
        logic [1:0] kind;
        logic [1:0] other;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            cap = int'(det_cfg.validating_timeout);
            if (int'(det_cfg.attached_timeout) > cap)
                cap = int'(det_cfg.attached_timeout);
            cap = (cap + 3 > 40) ? 40 : cap + 3;
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, cap) : $urandom_range(1, 6);
            repeat (n) add_item(idle_item());
        end
        else if (r == 1)
        begin
            n = $urandom_range(1, 5);
            repeat (n) add_item(raw_item(1'b1, $urandom_range(0, 65535),
                                         $urandom_range(0, 65535), $urandom_range(0, 65535)));
        end
        else if (r == 2)
        begin
            n = $urandom_range(1, 4);
            repeat (n) add_item(boundary_pulse());
        end
        else
        begin
            kind = ($urandom_range(0, 1) == 0) ? DEV_REMOTE : DEV_PROBE;
            other = (kind == DEV_REMOTE) ? DEV_PROBE : DEV_REMOTE;
            n = int'(det_cfg.validate_count) + $urandom_range(2, 20);
            repeat (n)
            begin
                r = $urandom_range(0, 99);
                if (r < 86)
                    add_item(class_pulse(kind));
                else if (r < 91)
                    add_item(idle_item());
                else if (r < 95)
                    add_item(class_pulse(other));
                else
                    add_item(make_pulse($urandom_range(0, int'(det_cfg.min_high_time)),
                                        $urandom_range(0, 65534)));
            end
        end
    endtask

    task automatic queue_random(int count);
        int target;
        target = items_queued + count;
        while (items_queued < target)
            queue_session();
    endtask

    task automatic wait_drained();
        while (items_taken != items_queued || expected_reports.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_BITS-1:0] index, int value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data <= DATA_BITS'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_settings(cfg_t s);
        write_reg(REG_MIN_HIGH, s.min_high_time);
        write_reg(REG_MIN_PERIOD, s.min_period);
        write_reg(REG_REMOTE_LIMIT, s.remote_period_limit);
        write_reg(REG_PROBE_LOW, s.probe_period_low);
        write_reg(REG_PROBE_HIGH, s.probe_period_high);
        write_reg(REG_VALIDATE_COUNT, s.validate_count);
        write_reg(REG_VALID_TIMEOUT, s.validating_timeout);
        write_reg(REG_ATTACH_TIMEOUT, s.attached_timeout);
        det_cfg = s;
        steady_flow <= ($urandom_range(0, 3) == 0);
    endtask

    function automatic cfg_t make_settings(int mh, int mp, int rl, int pl, int phi,
                                           int vc, int vt, int at);
        cfg_t s;
        s.min_high_time = TIME_BITS'(mh);
        s.min_period = TIME_BITS'(mp);
        s.remote_period_limit = TIME_BITS'(rl);
        s.probe_period_low = TIME_BITS'(pl);
        s.probe_period_high = TIME_BITS'(phi);
        s.validate_count = RUN_BITS'(vc);
        s.validating_timeout = IDLE_BITS'(vt);
        s.attached_timeout = IDLE_BITS'(at);
        return s;
    endfunction

    function automatic cfg_t random_settings();
        int mp;
        int rl;
        int pl;
        mp = $urandom_range(0, 3000);
        rl = $urandom_range(mp, mp + 5000);
        pl = $urandom_range(rl, rl + 10000);
        return make_settings($urandom_range(0, 2000), mp, rl, pl,
                             $urandom_range(pl + 2, 65535), $urandom_range(0, 30),
                             $urandom_range(0, 40), $urandom_range(0, 40));
    endfunction

    task automatic run_phase(cfg_t s, int count, logic squeeze);
        wait_drained();
        load_settings(s);
        queue_random(count);
        if (squeeze)
            pressure_reqs <= pressure_reqs + 1;
    endtask

    initial
    begin
        det_cfg = make_settings(100, 250, 1000, 3000, 20000, 20, 10000, 100);
        phase_now = PH_SEARCH;
        device_now = DEV_NONE;
        device_before = DEV_NONE;
        run_count = '0;
        idle_count = '0;
        held_high = '0;
        held_low = '0;
        held_period = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: timestamp extremes, wraparound and threshold edges.
        add_item(idle_item());
        add_item(raw_item(1'b1, 0, 0, 0));
        add_item(raw_item(1'b1, 0, 16'hFFFF, 16'hFFFF));
        add_item(raw_item(1'b1, 16'hFFFF, 0, 16'hFFFF));
        add_item(raw_item(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        add_item(raw_item(1'b1, 16'hFF00, 16'h0010, 16'h0010 + 200));
        add_item(make_pulse(100, 150));
        add_item(make_pulse(40000, 40000));
        add_item(make_pulse(50, 400));
        add_item(make_pulse(30000, 30000));
        queue_random(150);
        pressure_reqs <= pressure_reqs + 1;

        // Short run count: attach, accept, lose the device, validating timeout.
        wait_drained();
        load_settings(make_settings(100, 250, 1000, 3000, 20000, 2, 2, 3));
        repeat (5) add_item(make_pulse(200, 300));
        repeat (5) add_item(make_pulse(2000, 3000));
        add_item(idle_item());
        add_item(make_pulse(200, 300));
        repeat (3) add_item(idle_item());

        run_phase(make_settings(0, 0, 0, 0, 0, 0, 0, 0), 40, 1'b0);
        run_phase(make_settings(65535, 65535, 65535, 65535, 65535, 30, 16383, 16383),
                  40, 1'b0);
        run_phase(make_settings(50, 120, 600, 900, 4000, 4, 6, 9), 200, 1'b1);
        run_phase(random_settings(), 120, 1'b0);
        run_phase(random_settings(), 120, 1'b0);
        wait_drained();

        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
